// File: hw/rtl/jmc_pkg.sv
`timescale 1ns / 1ps

package jmc_pkg;

  // Default width of the brace depth counter.
  localparam int DEPTH_BITS_DEF = 8;

  // Characters the scanner reacts to.
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_LF        = 8'h0A;

  // Key slots, also the bit order of the key flags.
  localparam int KEY_RESULT = 0;
  localparam int KEY_ERROR  = 1;
  localparam int KEY_ID     = 2;
  localparam int NUM_KEYS   = 3;

  typedef enum logic [1:0] {
    KIND_RESPONSE     = 2'd0,
    KIND_REQUEST      = 2'd1,
    KIND_NOTIFICATION = 2'd2,
    KIND_UNKNOWN      = 2'd3
  } msg_kind_t;

  typedef struct packed {
    logic       method_seen;
    logic       has_id;
    logic       has_error;
    logic       has_result;
    msg_kind_t  message_kind;
  } result_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  // The quoted token "method", quotes included.
  function automatic logic [7:0] token_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = CH_QUOTE;
      3'd1:    c = 8'h6D; // m
      3'd2:    c = 8'h65; // e
      3'd3:    c = 8'h74; // t
      3'd4:    c = 8'h68; // h
      3'd5:    c = 8'h6F; // o
      3'd6:    c = 8'h64; // d
      default: c = CH_QUOTE;
    endcase
    return c;
  endfunction

  // Character idx of key k; zero beyond the end of the key.
  function automatic logic [7:0] key_char(input logic [1:0] k, input logic [2:0] idx);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      2'd0: begin
        case (idx)
          3'd0:    c = 8'h72; // r
          3'd1:    c = 8'h65; // e
          3'd2:    c = 8'h73; // s
          3'd3:    c = 8'h75; // u
          3'd4:    c = 8'h6C; // l
          3'd5:    c = 8'h74; // t
          default: c = 8'h00;
        endcase
      end
      2'd1: begin
        case (idx)
          3'd0:    c = 8'h65; // e
          3'd1:    c = 8'h72; // r
          3'd2:    c = 8'h72; // r
          3'd3:    c = 8'h6F; // o
          3'd4:    c = 8'h72; // r
          default: c = 8'h00;
        endcase
      end
      2'd2: begin
        case (idx)
          3'd0:    c = 8'h69; // i
          3'd1:    c = 8'h64; // d
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] key_len(input logic [1:0] k);
    logic [2:0] n;
    case (k)
      2'd0:    n = 3'd6;
      2'd1:    n = 3'd5;
      2'd2:    n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

// File: hw/rtl/jmc_scanner.sv
`timescale 1ns / 1ps

// Per-byte scanner state. Every accepted byte updates the state;
// on the last byte of a message the summary is presented combinationally and
// the state returns to its reset values.
module jmc_scanner #(
  parameter int DEPTH_BITS = jmc_pkg::DEPTH_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        data,
  input  logic              last,
  output jmc_pkg::result_t  res
);

  typedef enum logic [1:0] {
    PH_LEAD = 2'd0,
    PH_BODY = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = DEPTH_BITS'(1);

  phase_t                  phase_r,    phase_nxt;
  logic [DEPTH_BITS-1:0]   depth_r,    depth_nxt;
  // Quoted text: every string is a key candidate, so one flag covers both
  // the string state and the key collection state.
  logic                    in_key_r,   in_key_nxt;
  logic                    escape_r,   escape_nxt;
  logic                    await_r,    await_nxt;
  logic [2:0]              klen_r,     klen_nxt;
  logic [2:0]              alive_r,    alive_nxt;
  logic [2:0]              found_r,    found_nxt;
  logic [3:0]              tok_pos_r,  tok_pos_nxt;
  logic                    tok_found_r, tok_found_nxt;
  logic                    plain_byte;
  logic                    ws;

  assign ws = jmc_pkg::is_ws(data);

  always_comb begin
    phase_nxt     = phase_r;
    depth_nxt     = depth_r;
    in_key_nxt    = in_key_r;
    escape_nxt    = escape_r;
    await_nxt     = await_r;
    klen_nxt      = klen_r;
    alive_nxt     = alive_r;
    found_nxt     = found_r;
    tok_pos_nxt   = tok_pos_r;
    tok_found_nxt = tok_found_r;
    plain_byte    = 1'b0;

    // Method token matcher runs over the whole text until it hits.
    if (!tok_found_r) begin
      if (!tok_pos_r[3] && (data == jmc_pkg::token_char(tok_pos_r[2:0]))) begin
        tok_pos_nxt = tok_pos_r + 4'd1;
        if (tok_pos_nxt[3]) begin
          tok_found_nxt = 1'b1;
        end
      end else begin
        tok_pos_nxt = (data == jmc_pkg::CH_QUOTE) ? 4'd1 : 4'd0;
      end
    end

    case (phase_r)
      PH_LEAD: begin
        if (data == jmc_pkg::CH_LBRACE) begin
          phase_nxt = PH_BODY;
          depth_nxt = DEPTH_ONE;
        end else if (!ws) begin
          phase_nxt = PH_DONE;
        end
      end
      PH_BODY: begin
        if (in_key_r) begin
          if (escape_r) begin
            escape_nxt = 1'b0;
          end else if (data == jmc_pkg::CH_BACKSLASH) begin
            escape_nxt = 1'b1;
          end else if (data == jmc_pkg::CH_QUOTE) begin
            in_key_nxt = 1'b0;
            await_nxt  = 1'b1;
            for (int k = 0; k < jmc_pkg::NUM_KEYS; k++) begin
              if (klen_r != jmc_pkg::key_len(2'(k))) begin
                alive_nxt[k] = 1'b0;
              end
            end
          end else begin
            for (int k = 0; k < jmc_pkg::NUM_KEYS; k++) begin
              if ((klen_r >= jmc_pkg::key_len(2'(k))) ||
                  (data != jmc_pkg::key_char(2'(k), klen_r))) begin
                alive_nxt[k] = 1'b0;
              end
            end
            if (klen_r != 3'd7) begin
              klen_nxt = klen_r + 3'd1;
            end
          end
        end else begin
          plain_byte = 1'b1;
          if (await_r) begin
            if (ws) begin
              plain_byte = 1'b0;
            end else begin
              await_nxt = 1'b0;
              if (data == jmc_pkg::CH_COLON) begin
                plain_byte = 1'b0;
                if (depth_r == DEPTH_ONE) begin
                  found_nxt = found_r | alive_r;
                end
              end
            end
          end
          if (plain_byte) begin
            if (data == jmc_pkg::CH_QUOTE) begin
              in_key_nxt = 1'b1;
              escape_nxt = 1'b0;
              klen_nxt   = 3'd0;
              alive_nxt  = 3'b111;
            end else if (data == jmc_pkg::CH_LBRACE) begin
              if (!(&depth_r)) begin
                depth_nxt = depth_r + DEPTH_ONE;
              end
            end else if (data == jmc_pkg::CH_RBRACE) begin
              if (|depth_r) begin
                depth_nxt = depth_r - DEPTH_ONE;
                if (depth_r == DEPTH_ONE) begin
                  phase_nxt = PH_DONE;
                end
              end else begin
                phase_nxt = PH_DONE;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.has_result  = found_nxt[jmc_pkg::KEY_RESULT];
    res.has_error   = found_nxt[jmc_pkg::KEY_ERROR];
    res.has_id      = found_nxt[jmc_pkg::KEY_ID];
    res.method_seen = tok_found_nxt;
    if (found_nxt[jmc_pkg::KEY_RESULT] || found_nxt[jmc_pkg::KEY_ERROR]) begin
      res.message_kind = jmc_pkg::KIND_RESPONSE;
    end else if (tok_found_nxt) begin
      res.message_kind = found_nxt[jmc_pkg::KEY_ID] ? jmc_pkg::KIND_REQUEST
                                                   : jmc_pkg::KIND_NOTIFICATION;
    end else begin
      res.message_kind = jmc_pkg::KIND_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last)) begin
      phase_r     <= PH_LEAD;
      depth_r     <= DEPTH_ONE;
      in_key_r    <= 1'b0;
      escape_r    <= 1'b0;
      await_r     <= 1'b0;
      klen_r      <= 3'd0;
      alive_r     <= 3'b111;
      found_r     <= 3'd0;
      tok_pos_r   <= 4'd0;
      tok_found_r <= 1'b0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      depth_r     <= depth_nxt;
      in_key_r    <= in_key_nxt;
      escape_r    <= escape_nxt;
      await_r     <= await_nxt;
      klen_r      <= klen_nxt;
      alive_r     <= alive_nxt;
      found_r     <= found_nxt;
      tok_pos_r   <= tok_pos_nxt;
      tok_found_r <= tok_found_nxt;
    end
  end

endmodule

// File: hw/rtl/jsonrpc_message_classifier_top.sv
`timescale 1ns / 1ps

// Channel  Direction  Ports               Word contents
// in       slave      in_tvalid/tready    tdata: text byte; tlast: last byte of message
// out      master     out_tvalid/tready   tdata: kind, result, error, id, method flags
//
// One text byte is taken per clock while in_tready is high. The scanner state
// updates in the cycle the byte is accepted; the last byte of a message produces a
// registered result word, shown in the next cycle if out is free, else held in the skid.
// Reset (rst_n low, synchronous) clears the scanner and empties both result registers.
// A result register plus one skid register sit on the out side, so bytes keep
// flowing while a result waits; in_tready drops only when both hold a word.
module jsonrpc_message_classifier_top #(
  parameter int DEPTH_BITS = jmc_pkg::DEPTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [1:0] message_kind, [2] has_result, [3] has_error,
                                  // [4] has_id, [5] method_seen, [7:6] zero
);

  jmc_pkg::result_t  scan_res;
  jmc_pkg::result_t  out_r;
  jmc_pkg::result_t  skid_r;
  logic              out_valid_r;
  logic              skid_valid_r;
  logic              in_fire;
  logic              push;
  logic              pop;

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign push      = in_fire && in_tlast;
  assign pop       = out_valid_r && out_tready;

  jmc_scanner #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_scanner (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (in_fire),
    .data  (in_tdata),
    .last  (in_tlast),
    .res   (scan_res)
  );

  // Result register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || pop) begin
        if (skid_valid_r) begin
          out_r        <= skid_r;
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else if (push) begin
          out_r       <= scan_res;
          out_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b0;
        end
      end else if (push) begin
        skid_r       <= scan_res;
        skid_valid_r <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_r};

  // The skid register only fills behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held without a result word in front");

  // A message end with an empty output side shows up in the next cycle.
  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !out_valid_r) |=> out_tvalid)
    else $error("result of a finished message was not presented");

  // With no message end and no word taken, the output side keeps its state.
  a_quiet_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!push && !pop) |=> (out_tvalid == $past(out_tvalid)) &&
                        (skid_valid_r == $past(skid_valid_r)))
    else $error("result queue changed without a push or a pop");

endmodule
